### src/multi_channel_square_tone_generator_top_assert.svh
// Assertion macros for the checker file of the tone generator.
`ifndef MULTI_CHANNEL_SQUARE_TONE_GENERATOR_TOP_ASSERT_SVH
`define MULTI_CHANNEL_SQUARE_TONE_GENERATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCSTG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tone generator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MCSTG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tone generator assertion failed");

`endif

### src/mcstg_pkg.sv
`default_nettype none

package mcstg_pkg;

   localparam int NUM_CHANNELS_DEFAULT = 64;
   localparam int CHAN_W               = 6;
   localparam int FREQ_IN_W            = 16;
   localparam int FREQ_W               = 13;
   localparam int PERIOD_W             = 19;
   localparam int PIN_W                = 64;
   localparam int QUEUE_DEPTH          = 2;

   localparam logic [FREQ_W-1:0]   FREQ_CEILING   = 13'd5000;
   localparam logic [FREQ_W-1:0]   MAX_FREQ_RESET = 13'd5000;
   localparam logic [PERIOD_W-1:0] HALF_NUMERATOR = 19'd500000;

   typedef enum logic [1:0] {
      CMD_CREATE = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_STOP   = 2'd2,
      CMD_TICK   = 2'd3
   } command_type;

   typedef struct packed {
      command_type       command;
      logic              chan_ok;
      logic [CHAN_W-1:0] channel;
      logic [FREQ_W-1:0] frequency;
   } entry_type;

endpackage

`default_nettype wire

### src/mcstg_req_if.sv
`default_nettype none

interface mcstg_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          command;
   logic [mcstg_pkg::CHAN_W-1:0]        channel;
   logic signed [mcstg_pkg::FREQ_IN_W-1:0] frequency;

   modport source (output valid, command, channel, frequency, input ready);
   modport sink   (input valid, command, channel, frequency, output ready);
endinterface

`default_nettype wire

### src/mcstg_rsp_if.sv
`default_nettype none

interface mcstg_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [mcstg_pkg::PIN_W-1:0] pin_levels;
   logic                        status;

   modport source (output valid, pin_levels, status, input ready);
   modport sink   (input valid, pin_levels, status, output ready);
endinterface

`default_nettype wire

### src/mcstg_csr_if.sv
`default_nettype none

interface mcstg_csr_if;
   logic                         valid;
   logic                         ready;
   logic [mcstg_pkg::FREQ_W-1:0] max_frequency;

   modport source (output valid, max_frequency, input ready);
   modport sink   (input valid, max_frequency, output ready);
endinterface

`default_nettype wire

### src/mcstg_front.sv
`default_nettype none

module mcstg_front #(
   parameter int NUM_CHANNELS = mcstg_pkg::NUM_CHANNELS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   mcstg_req_if.sink                  req_bus,
   mcstg_csr_if.sink                  csr_bus,
   output logic                       push_valid,
   input  wire logic                  push_ready,
   output mcstg_pkg::entry_type       push_entry
);

   logic [mcstg_pkg::FREQ_W-1:0] max_freq_ff;
   logic [mcstg_pkg::FREQ_W-1:0] max_freq_in;
   logic [mcstg_pkg::FREQ_W-1:0] limit;
   logic [mcstg_pkg::FREQ_W-1:0] freq_clamped;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      max_freq_in = max_freq_ff;
      if (csr_bus.valid) begin
         max_freq_in = csr_bus.max_frequency;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_freq_ff <= mcstg_pkg::MAX_FREQ_RESET;
      end else begin
         max_freq_ff <= max_freq_in;
      end
   end

   // Negative requests become zero, large ones the effective ceiling.
   always_comb begin
      limit = (max_freq_ff > mcstg_pkg::FREQ_CEILING) ? mcstg_pkg::FREQ_CEILING : max_freq_ff;
      if (req_bus.frequency[mcstg_pkg::FREQ_IN_W-1]) begin
         freq_clamped = '0;
      end else if (req_bus.frequency[mcstg_pkg::FREQ_IN_W-2:0] >
                   {{(mcstg_pkg::FREQ_IN_W-1-mcstg_pkg::FREQ_W){1'b0}}, limit}) begin
         freq_clamped = limit;
      end else begin
         freq_clamped = req_bus.frequency[mcstg_pkg::FREQ_W-1:0];
      end
   end

   always_comb begin
      push_entry.command   = mcstg_pkg::command_type'(req_bus.command);
      push_entry.chan_ok   = {1'b0, req_bus.channel} < (mcstg_pkg::CHAN_W+1)'(NUM_CHANNELS);
      push_entry.channel   = req_bus.channel;
      push_entry.frequency = freq_clamped;
   end

   assign push_valid    = req_bus.valid;
   assign req_bus.ready = push_ready;

endmodule

`default_nettype wire

### src/mcstg_queue.sv
`default_nettype none

module mcstg_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   output logic                       push_ready,
   input  wire mcstg_pkg::entry_type  push_entry,
   output logic                       pop_valid,
   input  wire logic                  pop_ready,
   output mcstg_pkg::entry_type       pop_entry
);

   localparam int PTR_W = (mcstg_pkg::QUEUE_DEPTH > 1) ? $clog2(mcstg_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(mcstg_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(mcstg_pkg::QUEUE_DEPTH - 1);

   mcstg_pkg::entry_type slot_ff [mcstg_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push_fire;
   logic             pop_fire;

   assign push_ready = count_ff != CNT_W'(mcstg_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### src/mcstg_back.sv
`default_nettype none

module mcstg_back #(
   parameter int NUM_CHANNELS = mcstg_pkg::NUM_CHANNELS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pop_valid,
   output logic                       pop_ready,
   input  wire mcstg_pkg::entry_type  pop_entry,
   mcstg_rsp_if.source                rsp_bus
);

   localparam int IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int SWEEP_W   = $clog2(NUM_CHANNELS + 1);
   localparam int PW        = mcstg_pkg::PERIOD_W;
   localparam int FW        = mcstg_pkg::FREQ_W;
   localparam int DIV_CNT_W = $clog2(PW);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_SWEEP  = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

   typedef struct packed {
      logic [PW-1:0] half;
      logic [PW-1:0] tick;
   } phase_type;

   // Per-channel half period quotient of the stored frequency, and phase state.
   logic [PW-1:0] quot_mem  [NUM_CHANNELS];
   phase_type     phase_mem [NUM_CHANNELS];

   state_type              state_ff, state_in;
   logic [NUM_CHANNELS-1:0] running_ff, running_in;
   logic [NUM_CHANNELS-1:0] level_ff, level_in;
   logic                   status_ff, status_in;
   logic [IDX_W-1:0]       cur_idx_ff, cur_idx_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic [FW-1:0]          rem_ff, rem_in;
   logic [PW-1:0]          quot_ff, quot_in;
   logic [PW-1:0]          num_ff, num_in;
   logic [FW-1:0]          divisor_ff, divisor_in;
   logic [SWEEP_W-1:0]     issue_ff, issue_in;
   logic                   pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]       pipe_idx_ff, pipe_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [mcstg_pkg::PIN_W-1:0] pins_ff, pins_in;
   logic                   rsp_status_ff, rsp_status_in;

   logic [PW-1:0]    quot_rd_ff;
   phase_type        phase_rd_ff;
   logic [IDX_W-1:0] rd_addr;

   logic             q_we;
   logic [IDX_W-1:0] q_wa;
   logic [PW-1:0]    q_wd;
   logic             ph_we;
   logic [IDX_W-1:0] ph_wa;
   phase_type        ph_wd;

   logic [IDX_W-1:0] head_idx;
   logic [FW:0]      trial;
   logic [FW:0]      diff;
   logic             trial_ge;
   logic             out_free;
   phase_type        adv_phase;
   logic             adv_level;
   logic             cur_level;
   logic             tick_ge;

   assign head_idx  = pop_entry.channel[IDX_W-1:0];
   assign pop_ready = state_ff == ST_IDLE;
   assign rd_addr   = issue_ff[IDX_W-1:0];
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;

   // One restoring division step per cycle.
   always_comb begin
      trial    = {rem_ff, num_ff[PW-1]};
      diff     = trial - {1'b0, divisor_ff};
      trial_ge = trial >= {1'b0, divisor_ff};
   end

   always_comb begin
      cur_level = level_ff[pipe_idx_ff];
      tick_ge   = phase_rd_ff.tick >= phase_rd_ff.half;
      adv_phase = phase_rd_ff;
      adv_level = cur_level;
      if (!cur_level && tick_ge) begin
         if (quot_rd_ff == '0) begin
            adv_phase = '0;
            adv_level = 1'b0;
         end else begin
            adv_phase.half = quot_rd_ff;
            adv_phase.tick = PW'(1);
            adv_level      = 1'b1;
         end
      end else if (cur_level && tick_ge) begin
         adv_phase.tick = PW'(1);
         adv_level      = 1'b0;
      end else begin
         adv_phase.tick = phase_rd_ff.tick + 1'b1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      running_in    = running_ff;
      level_in      = level_ff;
      status_in     = status_ff;
      cur_idx_in    = cur_idx_ff;
      div_cnt_in    = div_cnt_ff;
      rem_in        = rem_ff;
      quot_in       = quot_ff;
      num_in        = num_ff;
      divisor_in    = divisor_ff;
      issue_in      = issue_ff;
      pipe_vld_in   = 1'b0;
      pipe_idx_in   = pipe_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      pins_in       = pins_ff;
      rsp_status_in = rsp_status_ff;
      q_we          = 1'b0;
      q_wa          = head_idx;
      q_wd          = '0;
      ph_we         = 1'b0;
      ph_wa         = head_idx;
      ph_wd         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               status_in = 1'b0;
               state_in  = ST_RESULT;
               unique case (pop_entry.command)
                  mcstg_pkg::CMD_CREATE: begin
                     if (pop_entry.chan_ok) begin
                        if (running_ff[head_idx]) begin
                           status_in = 1'b1;
                        end else begin
                           running_in[head_idx] = 1'b1;
                           level_in[head_idx]   = 1'b0;
                           q_we  = 1'b1;
                           ph_we = 1'b1;
                        end
                     end
                  end
                  mcstg_pkg::CMD_WRITE: begin
                     if (pop_entry.chan_ok) begin
                        if (pop_entry.frequency == '0) begin
                           q_we = 1'b1;
                        end else begin
                           cur_idx_in = head_idx;
                           div_cnt_in = DIV_CNT_W'(PW - 1);
                           rem_in     = '0;
                           quot_in    = '0;
                           num_in     = mcstg_pkg::HALF_NUMERATOR;
                           divisor_in = pop_entry.frequency;
                           state_in   = ST_DIVIDE;
                        end
                     end
                  end
                  mcstg_pkg::CMD_STOP: begin
                     if (pop_entry.chan_ok && running_ff[head_idx]) begin
                        running_in[head_idx] = 1'b0;
                        level_in[head_idx]   = 1'b0;
                        ph_we = 1'b1;
                     end
                  end
                  mcstg_pkg::CMD_TICK: begin
                     issue_in = '0;
                     state_in = ST_SWEEP;
                  end
                  default: begin
                     state_in = ST_RESULT;
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            rem_in     = trial_ge ? diff[FW-1:0] : trial[FW-1:0];
            quot_in    = {quot_ff[PW-2:0], trial_ge};
            num_in     = {num_ff[PW-2:0], 1'b0};
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) begin
               q_we     = 1'b1;
               q_wa     = cur_idx_ff;
               q_wd     = {quot_ff[PW-2:0], trial_ge};
               state_in = ST_RESULT;
            end
         end
         ST_SWEEP: begin
            if (issue_ff != SWEEP_W'(NUM_CHANNELS)) begin
               issue_in    = issue_ff + 1'b1;
               pipe_vld_in = 1'b1;
               pipe_idx_in = rd_addr;
            end else if (!pipe_vld_ff) begin
               state_in = ST_RESULT;
            end
            if (pipe_vld_ff && running_ff[pipe_idx_ff]) begin
               ph_we                 = 1'b1;
               ph_wa                 = pipe_idx_ff;
               ph_wd                 = adv_phase;
               level_in[pipe_idx_ff] = adv_level;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               pins_in       = mcstg_pkg::PIN_W'(level_ff);
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= '0;
         level_ff     <= '0;
         status_ff    <= 1'b0;
         issue_ff     <= '0;
         pipe_vld_ff  <= 1'b0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         level_ff     <= level_in;
         status_ff    <= status_in;
         issue_ff     <= issue_in;
         pipe_vld_ff  <= pipe_vld_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_idx_ff    <= cur_idx_in;
      rem_ff        <= rem_in;
      quot_ff       <= quot_in;
      num_ff        <= num_in;
      divisor_ff    <= divisor_in;
      pipe_idx_ff   <= pipe_idx_in;
      pins_ff       <= pins_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         quot_mem[q_wa] <= q_wd;
      end
      quot_rd_ff <= quot_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ph_we) begin
         phase_mem[ph_wa] <= ph_wd;
      end
      phase_rd_ff <= phase_mem[rd_addr];
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.pin_levels = pins_ff;
   assign rsp_bus.status     = rsp_status_ff;

endmodule

`default_nettype wire

### src/multi_channel_square_tone_generator_top.sv
// Channel  Direction  Words carried
// req_bus  in         command, channel, frequency
// rsp_bus  out        pin_levels, status (one word per request word)
// csr_bus  in         max_frequency (always ready)
//
// Once a tick word leaves the queue, a sweep reads and writes one channel per cycle
// through the channel state memories. A nonzero frequency write runs the 19-step
// serial divider; create and stop go straight to the response. Reset is synchronous
// and clears all channels to stopped and low. Request words are queued two deep, and
// a stalled response holds its word.
`default_nettype none

module multi_channel_square_tone_generator_top #(
   parameter int NUM_CHANNELS = mcstg_pkg::NUM_CHANNELS_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mcstg_req_if.sink   req_bus,
   mcstg_rsp_if.source rsp_bus,
   mcstg_csr_if.sink   csr_bus
);

   logic                 push_valid;
   logic                 push_ready;
   mcstg_pkg::entry_type push_entry;
   logic                 pop_valid;
   logic                 pop_ready;
   mcstg_pkg::entry_type pop_entry;

   mcstg_front #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   mcstg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   mcstg_back #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

### src/mcstg_checker.sv
`default_nettype none

`include "multi_channel_square_tone_generator_top_assert.svh"

module mcstg_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [mcstg_pkg::PIN_W-1:0] rsp_pin_levels,
   input wire logic                        rsp_status
);

   // At most the queue, the word in the back end and the response register.
   localparam logic [2:0] MAX_PENDING = 3'(mcstg_pkg::QUEUE_DEPTH + 2);

   logic [2:0] pending_ff;
   logic [2:0] pending_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_fire && !req_fire) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `MCSTG_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `MCSTG_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_pin_levels) && $stable(rsp_status))
   `MCSTG_ASSERT_NOW(a_rsp_has_request, clock, reset, rsp_valid, pending_ff != 3'd0)
   `MCSTG_ASSERT_NOW(a_pending_bounded, clock, reset, 1'b1, pending_ff <= MAX_PENDING)

endmodule

bind multi_channel_square_tone_generator_top mcstg_checker u_mcstg_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_pin_levels (rsp_bus.pin_levels),
   .rsp_status     (rsp_bus.status)
);

`default_nettype wire

### tb/mcstg_tone_checker.sv
module mcstg_tone_checker
   import mcstg_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   mcstg_req_if      req,
   mcstg_rsp_if      rsp,
   mcstg_csr_if      csr,
   output int        fail_count,
   output int        backlog
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [PIN_W-1:0] pin_levels;
      logic             status;
   } level_word_t;

   level_word_t         awaited_words[$];
   int                  mismatch_total = 0;
   logic [FREQ_W-1:0]   freq_limit;
   logic                chan_running[64];
   logic [FREQ_W-1:0]   chan_freq[64];
   logic [PERIOD_W-1:0] chan_half[64];
   logic [PERIOD_W-1:0] chan_ticks[64];
   logic                chan_level[64];

   assign fail_count = mismatch_total;

   function automatic void advance_channel(int i);
      if (!chan_level[i] && chan_ticks[i] >= chan_half[i]) begin
         if (chan_freq[i] == '0) begin
            chan_half[i]  = '0;
            chan_ticks[i] = '0;
            chan_level[i] = 1'b0;
         end else begin
            chan_half[i]  = HALF_NUMERATOR / {6'b0, chan_freq[i]};
            chan_ticks[i] = 19'd1;
            chan_level[i] = 1'b1;
         end
      end else if (chan_level[i] && chan_ticks[i] >= chan_half[i]) begin
         chan_level[i] = 1'b0;
         chan_ticks[i] = 19'd1;
      end else begin
         chan_ticks[i] = chan_ticks[i] + 1'b1;
      end
   endfunction

   function automatic level_word_t step_tone_bank(command_type cmd, logic [CHAN_W-1:0] ch,
                                                  logic [FREQ_IN_W-1:0] freq_raw);
      level_word_t       word;
      logic [FREQ_W-1:0] lim;
      bit                in_range;
      int                i;
      word     = '0;
      in_range = int'(ch) < NUM_CHANNELS;
      lim      = (freq_limit > FREQ_CEILING) ? FREQ_CEILING : freq_limit;
      case (cmd)
         CMD_CREATE: begin
            if (in_range) begin
               if (chan_running[ch]) begin
                  word.status = 1'b1;
               end else begin
                  chan_running[ch] = 1'b1;
                  chan_freq[ch]    = '0;
                  chan_half[ch]    = '0;
                  chan_ticks[ch]   = '0;
                  chan_level[ch]   = 1'b0;
               end
            end
         end
         CMD_WRITE: begin
            if (in_range) begin
               if (freq_raw[FREQ_IN_W-1])
                  chan_freq[ch] = '0;
               else if (freq_raw > {3'b0, lim})
                  chan_freq[ch] = lim;
               else
                  chan_freq[ch] = freq_raw[FREQ_W-1:0];
            end
         end
         CMD_STOP: begin
            if (in_range && chan_running[ch]) begin
               chan_running[ch] = 1'b0;
               chan_half[ch]    = '0;
               chan_ticks[ch]   = '0;
               chan_level[ch]   = 1'b0;
            end
         end
         default: begin
            for (i = 0; i < NUM_CHANNELS; i++)
               if (chan_running[i])
                  advance_channel(i);
         end
      endcase
      for (i = 0; i < NUM_CHANNELS; i++)
         word.pin_levels[i] = chan_level[i];
      return word;
   endfunction

   always @(posedge clock) begin
      level_word_t want;
      level_word_t got;
      if (reset) begin
         freq_limit = MAX_FREQ_RESET;
         awaited_words.delete();
         foreach (chan_running[i]) begin
            chan_running[i] = 1'b0;
            chan_freq[i]    = '0;
            chan_half[i]    = '0;
            chan_ticks[i]   = '0;
            chan_level[i]   = 1'b0;
         end
      end else begin
         if (rsp.valid && rsp.ready) begin
            got.pin_levels = rsp.pin_levels;
            got.status     = rsp.status;
            if (awaited_words.size() == 0) begin
               $error("response word arrived with nothing awaited");
               mismatch_total++;
            end else begin
               want = awaited_words.pop_front();
               if (got.pin_levels !== want.pin_levels) begin
                  $error("pin_levels: expected %h, actual %h", want.pin_levels, got.pin_levels);
                  mismatch_total++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %b, actual %b", want.status, got.status);
                  mismatch_total++;
               end
            end
         end
         if (csr.valid && csr.ready)
            freq_limit = csr.max_frequency;
         if (req.valid && req.ready)
            awaited_words.push_back(step_tone_bank(command_type'(req.command), req.channel,
                                                   req.frequency));
      end
      backlog <= awaited_words.size();
   end

endmodule

### tb/multi_channel_square_tone_generator_top_tb.sv
module multi_channel_square_tone_generator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mcstg_pkg::*;

   logic clock = 1'b0;
   logic reset;
   logic rsp_take = 1'b0;
   int   fail_count;
   int   backlog;
   int   sender_idle_pct = 0;
   int   receiver_stall_pct = 0;

   mcstg_req_if req_bus ();
   mcstg_rsp_if rsp_bus ();
   mcstg_csr_if csr_bus ();

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   multi_channel_square_tone_generator_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   mcstg_tone_checker tone_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .csr        (csr_bus),
      .fail_count (fail_count),
      .backlog    (backlog)
   );

   assign rsp_bus.ready = rsp_take;

   always @(posedge clock) begin
      rsp_take <= ($urandom_range(99) >= receiver_stall_pct);
   end

   task automatic send_word(command_type cmd, logic [CHAN_W-1:0] ch,
                            logic [FREQ_IN_W-1:0] freq);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.command   <= cmd;
      req_bus.channel   <= ch;
      req_bus.frequency <= freq;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic wait_for_quiet();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
   endtask

   task automatic write_limit(logic [FREQ_W-1:0] value);
      csr_bus.valid         <= 1'b1;
      csr_bus.max_frequency <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_random_word();
      int                   pick;
      command_type          cmd;
      logic [FREQ_IN_W-1:0] freq;
      pick = $urandom_range(99);
      if (pick < 50)
         cmd = CMD_TICK;
      else if (pick < 70)
         cmd = CMD_WRITE;
      else if (pick < 87)
         cmd = CMD_CREATE;
      else
         cmd = CMD_STOP;
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: freq = 16'($urandom_range(5000, 2500));
         6:                freq = 16'($urandom);
         7:                freq = 16'h8000 | 16'($urandom);
         8:                freq = 16'($urandom_range(32767, 5001));
         default:          freq = 16'($urandom_range(2499));
      endcase
      send_word(cmd, 6'($urandom), freq);
   endtask

   task automatic run_phase(logic [FREQ_W-1:0] limit, int idle_send, int idle_recv,
                            int words, int pause_at);
      int n;
      write_limit(limit);
      sender_idle_pct    = idle_send;
      receiver_stall_pct = idle_recv;
      for (n = 0; n < words; n++) begin
         if (n == pause_at)
            wait_for_quiet();
         send_random_word();
      end
      wait_for_quiet();
   endtask

   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.command       <= CMD_TICK;
      req_bus.channel       <= '0;
      req_bus.frequency     <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.max_frequency <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_word(CMD_CREATE, 6'd0, 16'h0000);
      send_word(CMD_CREATE, 6'd0, 16'h0000);
      send_word(CMD_WRITE, 6'd0, 16'h7FFF);
      send_word(CMD_TICK, 6'd0, 16'h0000);
      send_word(CMD_WRITE, 6'd0, 16'h8000);
      send_word(CMD_TICK, 6'd63, 16'hFFFF);
      send_word(CMD_WRITE, 6'd0, 16'hFFFF);
      send_word(CMD_WRITE, 6'd0, 16'h0000);
      send_word(CMD_WRITE, 6'd0, 16'd5000);
      send_word(CMD_TICK, 6'd0, 16'h0000);
      send_word(CMD_CREATE, 6'd63, 16'hFFFF);
      send_word(CMD_WRITE, 6'd63, 16'd1);
      send_word(CMD_STOP, 6'd5, 16'h0000);
      send_word(CMD_WRITE, 6'd7, 16'd100);
      send_word(CMD_CREATE, 6'd7, 16'h0000);
      send_word(CMD_TICK, 6'd0, 16'h0000);
      send_word(CMD_STOP, 6'd63, 16'h0000);
      send_word(CMD_STOP, 6'd63, 16'h0000);
      send_word(CMD_WRITE, 6'd0, 16'd5001);
      send_word(CMD_TICK, 6'd0, 16'h0000);
      send_word(CMD_CREATE, 6'd63, 16'h0000);
      send_word(CMD_TICK, 6'd0, 16'h0000);
      wait_for_quiet();

      run_phase(13'd8191, 0, 0, 200, -1);
      run_phase(13'd5000, 61, 0, 250, 120);
      run_phase(13'd0, 0, 61, 150, -1);
      run_phase(13'd1, 36, 36, 150, -1);
      run_phase(13'($urandom_range(5000, 1)), 36, 36, 250, -1);
      run_phase(13'd4000, 0, 0, 280, -1);

      repeat (80) @(posedge clock);
      if (fail_count == 0 && backlog == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
